/* rtl/core/csrn_pkg.sv */
// Shared constants, command codes and the queue entry type for the sparse
// matrix-vector residual norm block. No dependencies.
`timescale 1ns / 1ps

package csrn_pkg;

  // Vector store geometry.
  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;

  // Field and datapath widths.
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 48;
  localparam int SUM_W  = 64;
  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Decoupling queue between the front end and the arithmetic back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Square root runs one result bit per cycle.
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int ROOT_CW    = $clog2(ROOT_STEPS);

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_NONZERO = 2'd1;
  localparam cmd_t CMD_CLOSE   = 2'd2;

  // One classified item for the back end. For a nonzero, a is the matrix
  // value and b the vector element; for a close, a is the right-hand side.
  typedef struct packed {
    logic              is_close;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              last;
  } op_t;

endpackage

/* rtl/core/csrn_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
// Depends on csrn_pkg for field widths.
`timescale 1ns / 1ps

interface csrn_in_if import csrn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] rhs;
  logic                     last_row;

  modport source  (output valid, cmd, index, value, rhs, last_row, input ready);
  modport sink    (input valid, cmd, index, value, rhs, last_row, output ready);
  modport monitor (input valid, ready, cmd, index, value, rhs, last_row);
endinterface

interface csrn_out_if import csrn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] row_product;
  logic [DATA_W-1:0]        residual_norm;
  logic                     norm_valid;

  modport source  (output valid, row_product, residual_norm, norm_valid, input ready);
  modport sink    (input valid, row_product, residual_norm, norm_valid, output ready);
  modport monitor (input valid, ready, row_product, residual_norm, norm_valid);
endinterface

/* rtl/core/csr_spmv_residual_norm.sv */
// A close-row beat passes the front stage and the queue, then the back end
// states S_RESID, S_SUM, S_ROOT (last row only) and S_EMIT to the result.
// Loads and nonzeros go at one beat per cycle while the queue has room; a close
// holds the back end until it is emitted while the queue absorbs new beats.
// Reset (rst_n, synchronous, active low) clears control, the row accumulator and
// the square sum; the vector store is not cleared and holds nothing until loaded.
`timescale 1ns / 1ps

// Top level of the CSR sparse matrix-vector residual norm engine.
// Depends on csrn_pkg, csrn_if, csrn_front, csrn_queue and csrn_back.
module csr_spmv_residual_norm import csrn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  csrn_in_if.sink    in_ch,
  csrn_out_if.source out_ch
);

  // The front end takes one beat per cycle while the queue has room. Load beats
  // write the vector store; nonzero beats start a store read at acceptance, and
  // the element arrives in the next cycle in the front stage, where the beat is
  // turned into a queue entry. Loads and unused commands never reach the queue.
  logic f2q_valid;
  logic f2q_ready;
  op_t  f2q_op;

  // The back end pops entries. Nonzeros go through a registered multiplier
  // and then into the saturating 48-bit row accumulator, so a stream of
  // nonzeros runs at full rate. A close waits until the last product has
  // been added, then saturates the row, squares the residual on the same
  // multiplier, adds it into the 64-bit saturating sum and, on the last row,
  // runs a restoring square root before loading the result register. The
  // result register lets the back end keep working while a finished result
  // waits to be taken.
  logic q2b_valid;
  logic q2b_ready;
  op_t  q2b_op;

  csrn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .push_op    (f2q_op)
  );

  csrn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f2q_valid),
    .push_ready (f2q_ready),
    .push_op    (f2q_op),
    .pop_valid  (q2b_valid),
    .pop_ready  (q2b_ready),
    .pop_op     (q2b_op)
  );

  csrn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q2b_valid),
    .pop_ready (q2b_ready),
    .pop_op    (q2b_op),
    .out_ch    (out_ch)
  );

endmodule

/* rtl/core/csrn_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module csrn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/core/csrn_front.sv */
// Front end: accepts input beats, writes loads into the vector store, reads
// the vector element for nonzeros and pushes classified items to the queue.
// Depends on csrn_pkg, csrn_if and csrn_ram.
`timescale 1ns / 1ps

module csrn_front import csrn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  csrn_in_if.sink   in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output op_t       push_op
);

  logic              accept;
  logic              in_range;
  logic              ram_we;
  logic              ram_re;
  logic [VEC_AW-1:0] ram_addr;
  logic [DATA_W-1:0] ram_rdata;

  logic              stg_v_r, stg_v_nxt;
  logic              stg_close_r;
  logic              stg_range_r;
  logic [DATA_W-1:0] stg_value_r;
  logic [DATA_W-1:0] stg_rhs_r;
  logic              stg_last_r;

  assign in_ch.ready = !stg_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.index) < 32'(VEC_DEPTH);
  assign ram_addr    = VEC_AW'(in_ch.index);
  assign ram_we      = accept && (in_ch.cmd == CMD_LOAD) && in_range;
  assign ram_re      = accept && (in_ch.cmd == CMD_NONZERO);

  csrn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VEC_DEPTH)
  ) u_vec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_ch.value),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (push_valid && push_ready) begin
      stg_v_nxt = 1'b0;
    end
    if (accept) begin
      case (in_ch.cmd) inside
        CMD_NONZERO, CMD_CLOSE: stg_v_nxt = 1'b1;
        default:                stg_v_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_close_r <= (in_ch.cmd == CMD_CLOSE);
      stg_range_r <= in_range;
      stg_value_r <= in_ch.value;
      stg_rhs_r   <= in_ch.rhs;
      stg_last_r  <= in_ch.last_row;
    end
  end

  // The RAM output holds while the stage is stalled, since no read is issued.
  assign push_valid       = stg_v_r;
  assign push_op.is_close = stg_close_r;
  assign push_op.a        = stg_close_r ? stg_rhs_r : stg_value_r;
  assign push_op.b        = (!stg_close_r && stg_range_r) ? ram_rdata : '0;
  assign push_op.last     = stg_close_r && stg_last_r;

endmodule

/* rtl/core/csrn_queue.sv */
// Short FIFO that decouples the front end from the arithmetic back end.
// Depends on csrn_pkg.
`timescale 1ns / 1ps

module csrn_queue import csrn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  op_t               q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_op     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

/* rtl/core/csrn_back.sv */
// Back end: multiply-accumulate of nonzeros, row close with squared
// residual, saturating sum, bit-serial square root and the result register.
// Depends on csrn_pkg and csrn_if.
`timescale 1ns / 1ps

module csrn_back import csrn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  op_t        pop_op,
  csrn_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_RUN,
    S_RESID,
    S_SUM,
    S_ROOT,
    S_EMIT
  } state_t;

  state_t                   state_r;
  logic                     mul_v_r;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [SUM_W-1:0]         sum_r;
  logic [DATA_W-1:0]        rhs_r;
  logic                     last_r;
  logic [DATA_W-1:0]        prod_r;
  logic [DATA_W+1:0]        rem_r;
  logic [DATA_W-1:0]        root_r;
  logic [SUM_W-1:0]         rad_r;
  logic [ROOT_CW-1:0]       cnt_r;
  logic                     out_v_r, out_v_nxt;
  logic [DATA_W-1:0]        out_prod_r;
  logic [DATA_W-1:0]        out_norm_r;
  logic                     out_nv_r;

  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_nz;
  logic [DATA_W-1:0]        prod_sat;
  logic signed [MUL_W-1:0]  resid;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_prod;
  logic [SUM_W:0]           sum_add;
  logic [SUM_W-1:0]         sum_sat;
  logic [DATA_W+3:0]        rem_t;
  logic [DATA_W+3:0]        trial;
  logic [DATA_W+3:0]        diff;
  logic                     out_free;

  // Product is floored to Q32.16 by dropping 16 bits; it fits in 48 bits.
  assign acc_sum = $signed({acc_r[ACC_W-1], acc_r})
                 + $signed({mul_r[SUM_W-1], mul_r[SUM_W-1:16]});

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_nz = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_nz = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    if ((&acc_r[ACC_W-1:DATA_W-1]) || !(|acc_r[ACC_W-1:DATA_W-1])) begin
      prod_sat = acc_r[DATA_W-1:0];
    end else begin
      prod_sat = acc_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign resid = $signed({prod_sat[DATA_W-1], prod_sat}) - $signed({rhs_r[DATA_W-1], rhs_r});

  // One shared signed multiplier: matrix value times vector element, or the
  // residual squared when a row closes.
  always_comb begin
    if (state_r == S_RESID) begin
      mul_a = resid;
      mul_b = resid;
    end else begin
      mul_a = $signed({pop_op.a[DATA_W-1], pop_op.a});
      mul_b = $signed({pop_op.b[DATA_W-1], pop_op.b});
    end
  end

  assign mul_prod = mul_a * mul_b;

  assign sum_add = {1'b0, sum_r} + {1'b0, mul_r[SUM_W-1:0]};
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  // Restoring square root, one result bit per cycle.
  assign rem_t = {rem_r, rad_r[SUM_W-1:SUM_W-2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign diff  = rem_t - trial;

  assign out_free  = !out_v_r || out_ch.ready;
  assign pop_ready = (state_r == S_RUN) && pop_valid && (!pop_op.is_close || !mul_v_r);

  // The result register fills from the emit state and empties when taken.
  assign out_v_nxt = ((state_r == S_EMIT) && out_free) || (out_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      mul_v_r <= 1'b0;
      acc_r   <= '0;
      sum_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      unique case (state_r)
        S_RUN: begin
          mul_v_r <= pop_ready && !pop_op.is_close;
          if (mul_v_r) begin
            acc_r <= acc_nz;
          end
          if (pop_ready) begin
            if (pop_op.is_close) begin
              rhs_r   <= pop_op.a;
              last_r  <= pop_op.last;
              state_r <= S_RESID;
            end else begin
              mul_r   <= mul_prod;
            end
          end
        end
        S_RESID: begin
          prod_r  <= prod_sat;
          mul_r   <= mul_prod;
          acc_r   <= '0;
          state_r <= S_SUM;
        end
        S_SUM: begin
          root_r <= '0;
          if (last_r) begin
            sum_r   <= '0;
            rad_r   <= sum_sat;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_ROOT;
          end else begin
            sum_r   <= sum_sat;
            state_r <= S_EMIT;
          end
        end
        S_ROOT: begin
          rad_r <= {rad_r[SUM_W-3:0], 2'b00};
          if (rem_t >= trial) begin
            rem_r  <= diff[DATA_W+1:0];
            root_r <= {root_r[DATA_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_t[DATA_W+1:0];
            root_r <= {root_r[DATA_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ROOT_CW'(ROOT_STEPS - 1)) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_prod_r <= prod_r;
            out_norm_r <= root_r;
            out_nv_r   <= last_r;
            state_r    <= S_RUN;
          end
        end
        default: state_r <= S_RUN;
      endcase
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.row_product   = out_prod_r;
  assign out_ch.residual_norm = out_norm_r;
  assign out_ch.norm_valid    = out_nv_r;

endmodule

/* rtl/core/csrn_checker.sv */
// Port-level checker for the residual norm engine and its bind statement.
// Depends on csrn_pkg and csrn_if.
`timescale 1ns / 1ps

module csrn_checker import csrn_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  csrn_in_if.sink    in_ch,
  csrn_out_if.source out_ch
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.row_product) && $stable(out_ch.residual_norm)
       && $stable(out_ch.norm_valid)))
    else $error("result beat changed while stalled");

  // The norm field is zero on every row but the last.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.norm_valid) |-> (out_ch.residual_norm == '0))
    else $error("nonzero norm on a row that is not the last");

  // Reset empties the result register.
  assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  // The input side is open right after reset.
  assert property (@(posedge clk) !rst_n |=> in_ch.ready)
    else $error("input not ready after reset");

endmodule

bind csr_spmv_residual_norm csrn_checker u_csrn_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

/* tb/norm_scoreboard.sv */
// Scoreboard for the CSR residual norm testbench: beat and result types, plus a class
// that mirrors the block's arithmetic and checks every result beat. Depends on csrn_pkg.
`timescale 1ns / 1ps

package norm_check_pkg;
  import csrn_pkg::*;

  // The spare command code; the block must drop it.
  localparam cmd_t CMD_UNUSED = 2'd3;

  localparam longint ACC_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;

  typedef struct packed {
    cmd_t                     cmd;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] rhs;
    logic                     last_row;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] row_product;
    logic [DATA_W-1:0]        residual_norm;
    logic                     norm_valid;
  } row_result_t;

  class spmv_norm_tracker;
    logic signed [DATA_W-1:0] vec_copy [VEC_DEPTH];
    longint                   row_acc;
    longint unsigned          sq_sum;
    row_result_t              expected_rows [$];
    int                       errors;

    function new();
      row_acc = 0;
      sq_sum  = 0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    // Updates the mirrored state for one accepted beat; a close queues its result.
    function void absorb_beat(in_beat_t b);
      longint          xv, part, acc_sum, prod, resid;
      longint unsigned mag, sq, rem, root, bitv;
      logic [64:0]     wide;
      row_result_t     r;
      case (b.cmd)
        CMD_LOAD: begin
          if (b.index < VEC_DEPTH) vec_copy[b.index] = b.value;
        end
        CMD_NONZERO: begin
          xv = 0;
          if (b.index < VEC_DEPTH) xv = longint'(vec_copy[b.index]);
          // Exact Q32.32 product, floored to Q32.16 by the arithmetic shift.
          part = longint'(b.value) * xv;
          acc_sum = row_acc + (part >>> 16);
          if (acc_sum > ACC_TOP) acc_sum = ACC_TOP;
          if (acc_sum < ACC_BOTTOM) acc_sum = ACC_BOTTOM;
          row_acc = acc_sum;
        end
        CMD_CLOSE: begin
          prod = row_acc;
          if (prod > 64'sd2147483647) prod = 64'sd2147483647;
          if (prod < -64'sd2147483648) prod = -64'sd2147483648;
          resid = prod - longint'(b.rhs);
          mag = (resid < 0) ? longint'(-resid) : resid;
          sq = mag * mag;
          wide = {1'b0, sq_sum} + {1'b0, sq};
          sq_sum = wide[64] ? '1 : wide[63:0];
          row_acc = 0;
          r.row_product   = prod[DATA_W-1:0];
          r.residual_norm = '0;
          r.norm_valid    = b.last_row;
          if (b.last_row) begin
            // Bit-pair integer square root, floor result.
            rem  = sq_sum;
            root = 0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
              if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
              end else begin
                root = root >> 1;
              end
              bitv = bitv >> 2;
            end
            r.residual_norm = root[DATA_W-1:0];
            sq_sum = 0;
          end
          expected_rows.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_row(row_result_t got);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result row_product=%0d residual_norm=%0d norm_valid=%0b",
                 $time, got.row_product, got.residual_norm, got.norm_valid);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_product !== want.row_product) begin
        $display("%0t: row_product expected %0d actual %0d",
                 $time, want.row_product, got.row_product);
        errors++;
      end
      if (got.residual_norm !== want.residual_norm) begin
        $display("%0t: residual_norm expected %0d actual %0d",
                 $time, want.residual_norm, got.residual_norm);
        errors++;
      end
      if (got.norm_valid !== want.norm_valid) begin
        $display("%0t: norm_valid expected %0b actual %0b",
                 $time, want.norm_valid, got.norm_valid);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/tb.sv */
// Top-level testbench for csr_spmv_residual_norm: directed corner beats, then random
// matrices under several idle and stall mixes. Depends on csrn_pkg, csrn_if, norm_check_pkg.
`timescale 1ns / 1ps

module tb;
  import csrn_pkg::*;
  import norm_check_pkg::*;

  // The cycle limit leaves a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 1050;
  // Settle time after the last drain, longer than a last-row close takes in the back end.
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;

  logic clk;
  logic rst_n;

  csrn_in_if  in_ch ();
  csrn_out_if out_ch ();

  csr_spmv_residual_norm u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  spmv_norm_tracker tracker;

  // Idle mix for the current phase, in percent of cycles.
  int send_idle_pct;
  int recv_stall_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  int hold_cycles_req;
  // Beats the block acts on; the spare command is not counted.
  int items_sent;

  // Generator-side record of which vector entries hold data, so that a nonzero
  // never reads an entry that was never loaded.
  bit          loaded [VEC_DEPTH];
  int unsigned loaded_list [$];

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stalls at random by the phase percentage, and on request holds
  // ready low for a long stretch that it counts itself.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        repeat (n) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Every accepted result beat goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.compare_row('{out_ch.row_product, out_ch.residual_norm, out_ch.norm_valid});
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly small Q16.16 values so that sums stay in range, with a share of
  // full-width random words and the extremes so saturation is reached often.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // Offers one beat and returns once it has been accepted. Valid is left high so
  // that back-to-back beats need no extra assignment; an idle cycle lowers it.
  task automatic offer_beat(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                            input logic [31:0] value, input logic [31:0] rhs,
                            input logic last_row);
    in_beat_t b;
    b = '{cmd, idx, value, rhs, last_row};
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= b.cmd;
    in_ch.index    <= b.index;
    in_ch.value    <= b.value;
    in_ch.rhs      <= b.rhs;
    in_ch.last_row <= b.last_row;
    do @(posedge clk); while (!in_ch.ready);
    tracker.absorb_beat(b);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic load_entry(input int unsigned idx, input logic [31:0] value);
    offer_beat(CMD_LOAD, idx[IDX_W-1:0], value, $urandom(), 1'($urandom_range(0, 1)));
    if (!loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  // The sender stops and waits until every expected result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // One random matrix: a few loads, then rows of nonzeros closed one by one.
  // Spare-command beats and stray loads are sprinkled in as noise, and now and
  // then the final close leaves last_row low so the square sum runs on into the
  // next matrix.
  task automatic run_matrix();
    int n_rows, n_loads, nnz;
    bit end_flag;
    n_rows  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    n_loads = $urandom_range(1, 10);
    end_flag = ($urandom_range(0, 9) != 0);
    repeat (n_loads) load_entry($urandom_range(0, VEC_DEPTH - 1), rand_word());
    for (int row = 0; row < n_rows; row++) begin
      nnz = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      repeat (nnz) begin
        case ($urandom_range(0, 29))
          0: offer_beat(CMD_UNUSED, IDX_W'($urandom()), $urandom(), $urandom(),
                        1'($urandom_range(0, 1)));
          1: load_entry($urandom_range(0, VEC_DEPTH - 1), rand_word());
          default: ;
        endcase
        offer_beat(CMD_NONZERO,
                   IDX_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
                   rand_word(), $urandom(), 1'($urandom_range(0, 1)));
      end
      offer_beat(CMD_CLOSE, IDX_W'($urandom()), $urandom(), rand_word(),
                 (row == n_rows - 1) && end_flag);
    end
  endtask

  initial begin
    int phase_end;
    int idle_mix [4][2];
    tracker = new();
    idle_mix = '{'{0, 0}, '{78, 0}, '{0, 78}, '{38, 38}};
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_cycles_req = 0;
    items_sent      = 0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_LOAD;
    in_ch.index    = '0;
    in_ch.value    = '0;
    in_ch.rhs      = '0;
    in_ch.last_row = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Loads of both extremes, one at each end of the index range,
    // with last_row set on a load to show the flag is ignored there.
    load_entry(0, 32'h7FFF_FFFF);
    offer_beat(CMD_LOAD, 10'h3FF, 32'h8000_0000, 32'h0, 1'b1);
    loaded[10'h3FF] = 1'b1;
    loaded_list.push_back(10'h3FF);
    load_entry(10'h155, 32'h0001_0000);
    load_entry(10'h2AA, 32'hFFFF_FFFF);
    // The spare command, all ones and all zeros, must change nothing.
    offer_beat(CMD_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    offer_beat(CMD_UNUSED, 10'h000, 32'h0, 32'h0, 1'b0);
    // 3.0 * 1.0, then a product of one ulp times minus one ulp, which floors
    // to minus one ulp rather than to zero.
    offer_beat(CMD_NONZERO, 10'h155, 32'h0003_0000, 32'h0, 1'b1);
    offer_beat(CMD_NONZERO, 10'h2AA, 32'h0000_0001, 32'h0, 1'b0);
    offer_beat(CMD_CLOSE, 10'h0, 32'h0, 32'h0001_0000, 1'b0);
    // An empty row: its product is zero and its residual is minus rhs.
    offer_beat(CMD_CLOSE, 10'h0, 32'h0, 32'h8000_0000, 1'b0);
    // Three near-maximal products drive the accumulator into positive
    // saturation; the row product then clamps and the square sum overflows.
    repeat (3) offer_beat(CMD_NONZERO, 10'h000, 32'h7FFF_FFFF, 32'h0, 1'b0);
    offer_beat(CMD_CLOSE, 10'h0, 32'h0, 32'h8000_0000, 1'b0);
    offer_beat(CMD_CLOSE, 10'h3FF, 32'hFFFF_FFFF, 32'h0, 1'b1);
    // The same saturation and clamp on the negative side.
    repeat (3) offer_beat(CMD_NONZERO, 10'h3FF, 32'h7FFF_FFFF, 32'h0, 1'b0);
    offer_beat(CMD_CLOSE, 10'h0, 32'h0, 32'h7FFF_FFFF, 1'b1);
    // Most negative times most negative is the largest single product.
    offer_beat(CMD_NONZERO, 10'h3FF, 32'h8000_0000, 32'h0, 1'b0);
    offer_beat(CMD_CLOSE, 10'h0, 32'h0, 32'h0, 1'b1);
    // An empty last row with nothing summed gives a norm of zero.
    offer_beat(CMD_CLOSE, 10'h0, 32'h0, 32'h0, 1'b1);
    drain_results();

    // Random part, one phase per idle mix. The first phase opens with a long
    // receiver hold-off while the sender keeps offering, which fills the
    // internal queue and must back-pressure the input.
    phase_end = items_sent;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_mix[p][0];
      recv_stall_pct = idle_mix[p][1];
      if (p == 0) hold_cycles_req = LONG_HOLD;
      phase_end = phase_end + RANDOM_ITEMS / 4;
      while (items_sent < phase_end) run_matrix();
      // Close any matrix left open so its norm is checked before the pause.
      offer_beat(CMD_CLOSE, IDX_W'($urandom()), $urandom(), rand_word(), 1'b1);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
